// File: rtl/prtd_pkg.sv
// Package for the prescaled reload timer / divider.
// Register map indexes, field widths and the prescaler period lookup.
// No dependencies.
`default_nettype none

package prtd_pkg;

  localparam int unsigned CountW  = 8;   // timer and divider count width
  localparam int unsigned TAccW   = 11;  // timer accumulator width
  localparam int unsigned DAccW   = 13;  // divider accumulator width
  localparam int unsigned PaddrW  = 4;   // byte address, three 32-bit registers
  localparam int unsigned PdataW  = 32;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_TIMER_ENABLE = 2'd0,
    REG_CLOCK_SELECT = 2'd1,
    REG_RELOAD_VALUE = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  // Prescaler period select codes
  typedef enum logic [1:0] {
    CLKSEL_1024 = 2'd0,
    CLKSEL_16   = 2'd1,
    CLKSEL_64   = 2'd2,
    CLKSEL_256  = 2'd3
  } clk_sel_t;

  // Period in machine cycles for a select code
  function automatic logic [TAccW-1:0] period_of(input logic [1:0] sel);
    logic [TAccW-1:0] p;
    case (sel)
      CLKSEL_1024: p = 11'd1024;
      CLKSEL_16:   p = 11'd16;
      CLKSEL_64:   p = 11'd64;
      CLKSEL_256:  p = 11'd256;
      default:     p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/prescaled_reload_timer_divider.sv
// Top level of the prescaled reload timer with free-running divider.
// Single-pass update of timer/divider state per input transaction, two-slot result buffer.
// Depends on prtd_pkg.
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+-------------------
//  in      | in_step_cycles                          | in        | in_valid/in_ready
//  out     | out_timer_count, out_divider_count,     | out       | out_valid/out_ready
//          | out_timer_interrupt                     |           |
//  cfg     | psel, penable, pwrite, paddr, pwdata,   | in/out    | APB, pready tied high
//          | prdata, pready                          |           |
//
// Cycles: one input transaction per clock while in_ready is high. The accumulate/compare/
//   subtract of both units is one combinational pass into the state registers; the
//   result lands in the output register, or in the skid register while a result waits.
// Stalls: a skid register behind the output register lets one more transaction in
//   while a result waits; in_ready drops only when both slots are full.
// Reset: rst_n synchronous, active low; clears config, accumulators, counters and
//   the valid flags of both result slots.
`default_nettype none

module prescaled_reload_timer_divider #(
  parameter int unsigned DIV_PERIOD      = 4096,  // 16..4096
  parameter int unsigned MAX_STEP_CYCLES = 255    // 1..255
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_step_cycles,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [prtd_pkg::CountW-1:0]       out_timer_count,
  output logic [prtd_pkg::CountW-1:0]       out_divider_count,
  output logic                              out_timer_interrupt,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [prtd_pkg::PaddrW-1:0]  paddr,
  input  wire logic [prtd_pkg::PdataW-1:0]  pwdata,
  output logic [prtd_pkg::PdataW-1:0]       prdata,
  output logic                              pready
);

  localparam int unsigned CW = prtd_pkg::CountW;
  localparam int unsigned TW = prtd_pkg::TAccW;
  localparam int unsigned DW = prtd_pkg::DAccW;

  localparam logic [7:0]    StepMax = 8'(MAX_STEP_CYCLES);
  localparam logic [DW:0]   DivPer  = (DW+1)'(DIV_PERIOD);
  localparam logic [CW-1:0] CntTop  = '1;

  typedef struct packed {
    logic [CW-1:0] tcount;
    logic [CW-1:0] dcount;
    logic          irq;
  } result_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic          timer_enable_r;
  logic [1:0]    clock_select_r;
  logic [CW-1:0] reload_value_r;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_enable_r <= 1'b0;
      clock_select_r <= 2'd0;
      reload_value_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        prtd_pkg::REG_TIMER_ENABLE: timer_enable_r <= pwdata[0];
        prtd_pkg::REG_CLOCK_SELECT: clock_select_r <= pwdata[1:0];
        prtd_pkg::REG_RELOAD_VALUE: reload_value_r <= pwdata[CW-1:0];
        default: ;  // no register here
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      prtd_pkg::REG_TIMER_ENABLE: prdata = {31'd0, timer_enable_r};
      prtd_pkg::REG_CLOCK_SELECT: prdata = {30'd0, clock_select_r};
      prtd_pkg::REG_RELOAD_VALUE: prdata = {24'd0, reload_value_r};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Timer / divider state and next-state logic
  // ---------------------------------------------------------------------------
  logic [TW-1:0] timer_accum_r,   timer_accum_nxt;
  logic [CW-1:0] timer_counter_r, timer_counter_nxt;
  logic [DW-1:0] div_accum_r,     div_accum_nxt;
  logic [CW-1:0] div_counter_r,   div_counter_nxt;
  logic          irq_nxt;

  logic [7:0]    step;
  logic [DW:0]   dsum, dsum_sub;
  logic [TW:0]   tsum, tsum_sub, tper;
  logic          push, pop;

  always_comb begin
    // clamp oversized steps
    step = (in_step_cycles > StepMax) ? StepMax : in_step_cycles;

    // free-running divider
    dsum            = {1'b0, div_accum_r} + (DW+1)'(step);
    div_counter_nxt = div_counter_r;
    dsum_sub        = dsum;
    if (dsum >= DivPer) begin
      dsum_sub        = dsum - DivPer;
      div_counter_nxt = div_counter_r + 1'b1;
    end
    div_accum_nxt = dsum_sub[DW] ? '1 : dsum_sub[DW-1:0];

    // prescaled timer, at most one count per transaction
    tper              = {1'b0, prtd_pkg::period_of(clock_select_r)};
    tsum              = {1'b0, timer_accum_r} + (TW+1)'(step);
    tsum_sub          = tsum;
    timer_counter_nxt = timer_counter_r;
    timer_accum_nxt   = timer_accum_r;
    irq_nxt           = 1'b0;
    if (timer_enable_r) begin
      if (tsum >= tper) begin
        tsum_sub = tsum - tper;
        if (timer_counter_r == CntTop) begin
          timer_counter_nxt = reload_value_r;  // overflow: reload and flag
          irq_nxt           = 1'b1;
        end else begin
          timer_counter_nxt = timer_counter_r + 1'b1;
        end
      end
      timer_accum_nxt = tsum_sub[TW] ? '1 : tsum_sub[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_accum_r   <= '0;
      timer_counter_r <= '0;
      div_accum_r     <= '0;
      div_counter_r   <= '0;
    end else if (push) begin
      timer_accum_r   <= timer_accum_nxt;
      timer_counter_r <= timer_counter_nxt;
      div_accum_r     <= div_accum_nxt;
      div_counter_r   <= div_counter_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register plus skid slot
  // ---------------------------------------------------------------------------
  result_t res_new;
  result_t out_r, skid_r;
  logic    out_v_r, skid_v_r;

  assign res_new  = '{tcount: timer_counter_nxt, dcount: div_counter_nxt, irq: irq_nxt};
  assign in_ready = ~skid_v_r;
  assign push     = in_valid & in_ready;
  assign pop      = out_v_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      // output slot frees up: drain skid first to keep order
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res_new;
      end
    end else if (push) begin
      skid_r <= res_new;
    end
  end

  assign out_valid           = out_v_r;
  assign out_timer_count     = out_r.tcount;
  assign out_divider_count   = out_r.dcount;
  assign out_timer_interrupt = out_r.irq;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // skid slot never holds data while the output slot is empty
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot valid with empty output slot");

  // after every accepted transaction the output slot holds a result in the next cycle
  a_push_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_v_r)
    else $error("accepted transaction produced no result");

  // disabled timer keeps its accumulator and counter
  a_timer_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !timer_enable_r) |=> ($stable(timer_accum_r) && $stable(timer_counter_r)))
    else $error("timer state moved while disabled");

  // interrupt only with the reload value loaded
  a_irq_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (push && irq_nxt) |=> (timer_counter_r == $past(reload_value_r)))
    else $error("timer overflow without reload");

endmodule

`default_nettype wire

// File: bench/prescaled_reload_timer_divider_tb.sv
// Self-checking bench for the prescaled reload timer / divider.
// Runs a directed table, then random ticks under a series of register settings.
// Depends on prtd_pkg and prescaled_reload_timer_divider.
module prescaled_reload_timer_divider_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DivPeriod    = 4096;
  localparam int unsigned MaxStep      = 255;
  localparam int unsigned TAccSat      = 2047;  // timer accumulator ceiling
  localparam int unsigned DAccSat      = 8191;  // divider accumulator ceiling
  localparam int unsigned SettleCycles = 4;     // extra settle after the last owed result
  localparam int unsigned StallLimit   = 400;   // cycles with no transaction at all
  localparam int unsigned LongHold     = 40;    // sink back-pressure stretch
  localparam int unsigned MaxReports   = 60;
  localparam int unsigned PhaseTicks   = 50;
  localparam int unsigned NumPhases    = 9;
  localparam int unsigned DirRows      = 29;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [7:0]                  in_step_cycles;
  logic                        out_valid;
  logic                        out_ready;
  logic [prtd_pkg::CountW-1:0] out_timer_count;
  logic [prtd_pkg::CountW-1:0] out_divider_count;
  logic                        out_timer_interrupt;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [prtd_pkg::PaddrW-1:0] paddr;
  logic [prtd_pkg::PdataW-1:0] pwdata;
  logic [prtd_pkg::PdataW-1:0] prdata;
  logic                        pready;

  prescaled_reload_timer_divider #(
    .DIV_PERIOD     (DivPeriod),
    .MAX_STEP_CYCLES(MaxStep)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_step_cycles     (in_step_cycles),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_timer_count    (out_timer_count),
    .out_divider_count  (out_divider_count),
    .out_timer_interrupt(out_timer_interrupt),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------------
  // One result transaction
  typedef struct packed {
    logic [prtd_pkg::CountW-1:0] timer_count;
    logic [prtd_pkg::CountW-1:0] divider_count;
    logic                        timer_interrupt;
  } tick_t;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  // Directed row: either a register write or a tick, optionally with a hand-typed result
  typedef struct packed {
    row_kind_t          kind;
    prtd_pkg::reg_idx_t idx;
    logic [31:0]        wdata;
    logic [7:0]         step;
    logic               typed;
    tick_t              want;
  } row_t;

  // Register setting for one random phase; gaps=0 means both sides run flat out
  typedef struct packed {
    logic               en;
    prtd_pkg::clk_sel_t sel;
    logic [7:0]         reload;
    logic               gaps;
  } setting_t;

  // ---------------------------------------------------------------------------
  // Shadow of the timer/divider state and registers
  // ---------------------------------------------------------------------------
  logic               en_q;
  prtd_pkg::clk_sel_t sel_q;
  logic [7:0]         reload_q;
  int unsigned        tmr_acc;
  int unsigned        tmr_cnt;
  int unsigned        div_acc;
  int unsigned        div_cnt;

  tick_t counts_due[$];   // results owed by the DUT, oldest first
  int    mismatches;
  int    idle_cycles;
  bit    gaps_on;         // random idling on both channels
  bit    long_hold;       // request for one long sink stall

  // Advance both units by one tick and return what the DUT should report.
  function automatic tick_t advance_timers(input logic [7:0] step);
    int unsigned cycles;
    int unsigned sum;
    int unsigned period;
    tick_t       r;
    cycles = (step > MaxStep) ? MaxStep : step;
    r.timer_interrupt = 1'b0;
    // divider never stops
    sum = div_acc + cycles;
    if (sum >= DivPeriod) begin
      sum -= DivPeriod;
      div_cnt = (div_cnt + 1) % 256;
    end
    div_acc = (sum > DAccSat) ? DAccSat : sum;
    // timer: at most one count per tick, leftover cycles carry over
    if (en_q) begin
      case (sel_q)
        prtd_pkg::CLKSEL_16:  period = 16;
        prtd_pkg::CLKSEL_64:  period = 64;
        prtd_pkg::CLKSEL_256: period = 256;
        default:              period = 1024;
      endcase
      sum = tmr_acc + cycles;
      if (sum >= period) begin
        sum -= period;
        if (tmr_cnt == 255) begin
          tmr_cnt = reload_q;
          r.timer_interrupt = 1'b1;
        end else begin
          tmr_cnt++;
        end
      end
      tmr_acc = (sum > TAccSat) ? TAccSat : sum;
    end
    r.timer_count   = 8'(tmr_cnt);
    r.divider_count = 8'(div_cnt);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Hand-typed results only where obvious: right after reset
  // with the timer off, and the first count with clock select CLKSEL_16.
  // ---------------------------------------------------------------------------
  row_t directed [DirRows] = '{
    // timer disabled after reset: only the divider accumulates
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd0,   1'b1, '{8'd0, 8'd0, 1'b0}},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b1, '{8'd0, 8'd0, 1'b0}},
    // write beyond the register map is dropped
    '{ROW_WRITE, prtd_pkg::REG_UNUSED, 32'hFFFF_FFFF, 8'd0, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd1,   1'b1, '{8'd0, 8'd0, 1'b0}},
    // junk in the upper bits must be masked off
    '{ROW_WRITE, prtd_pkg::REG_CLOCK_SELECT, {30'h3FFF_FFFF, prtd_pkg::CLKSEL_16},
      8'd0, 1'b0, '0},
    '{ROW_WRITE, prtd_pkg::REG_RELOAD_VALUE, 32'h0000_01FF, 8'd0, 1'b0, '0},
    '{ROW_WRITE, prtd_pkg::REG_TIMER_ENABLE, 32'hFFFF_FFFF, 8'd0, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b1, '{8'd1, 8'd0, 1'b0}},
    // long steps on a short period: accumulator runs up to its ceiling
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b0, '0},
    // period change keeps the accumulated cycles
    '{ROW_WRITE, prtd_pkg::REG_CLOCK_SELECT, 32'(prtd_pkg::CLKSEL_1024), 8'd0, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd0,   1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd0,   1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd1,   1'b0, '0},
    // exact boundary and one short of it
    '{ROW_WRITE, prtd_pkg::REG_CLOCK_SELECT, 32'(prtd_pkg::CLKSEL_64), 8'd0, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd64,  1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd63,  1'b0, '0},
    '{ROW_WRITE, prtd_pkg::REG_CLOCK_SELECT, 32'(prtd_pkg::CLKSEL_256), 8'd0, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd200, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd56,  1'b0, '0},
    // timer off again: counter and accumulator freeze
    '{ROW_WRITE, prtd_pkg::REG_TIMER_ENABLE, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd255, 1'b0, '0},
    '{ROW_TICK,  prtd_pkg::REG_UNUSED, 32'h0, 8'd128, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Config port: setup, access, then idle with psel low, so back-to-back writes
  // never touch psel twice in the same step. Call at a rising edge.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input prtd_pkg::reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= prtd_pkg::PaddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      prtd_pkg::REG_TIMER_ENABLE: en_q     = data[0];
      prtd_pkg::REG_CLOCK_SELECT: sel_q    = prtd_pkg::clk_sel_t'(data[1:0]);
      prtd_pkg::REG_RELOAD_VALUE: reload_q = data[7:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering and let every owed result come back, plus a short settle.
  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (counts_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Offer one tick and wait for the input transaction. Within a run of ticks, in_valid
  // is only dropped when a gap is drawn, so a flat-out stream keeps it high.
  task automatic offer_tick(input logic [7:0] step, input logic typed, input tick_t want);
    int unsigned gap;
    tick_t       due;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_step_cycles <= step;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due = advance_timers(step);
    counts_due.push_back(typed ? want : due);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold on request so the
  // two-slot output fills and in_ready drops while ticks keep coming.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        stall = gaps_on ? $urandom_range(0, 4) : 0;
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each result transaction against the oldest owed result
  always @(posedge clk) begin : check_results
    tick_t want;
    if (rst_n && out_valid && out_ready) begin
      if (counts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result with none expected, got timer %0d divider %0d irq %0d",
                   $time, out_timer_count, out_divider_count, out_timer_interrupt);
      end else begin
        want = counts_due.pop_front();
        check_field("timer_count", want.timer_count, out_timer_count);
        check_field("divider_count", want.divider_count, out_divider_count);
        check_field("timer_interrupt", want.timer_interrupt, out_timer_interrupt);
      end
    end
  end

  // Watchdog: give up when no transaction of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAIL prescaled_reload_timer_divider");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    setting_t   plan [NumPhases];
    logic [7:0] step;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_step_cycles = '0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    gaps_on        = 1'b1;
    long_hold      = 1'b0;
    mismatches     = 0;
    idle_cycles    = 0;
    en_q           = 1'b0;
    sel_q          = prtd_pkg::CLKSEL_1024;
    reload_q       = '0;
    tmr_acc        = 0;
    tmr_cnt        = 0;
    div_acc        = 0;
    div_cnt        = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part; register writes only once the DUT has drained
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        wait_for_results();
        write_reg(directed[i].idx, directed[i].wdata);
      end else begin
        offer_tick(directed[i].step, directed[i].typed, directed[i].want);
      end
    end

    // Random phases. The timer counter starts low, so the early phases run it
    // up quickly; the high reload values come late, where wraps happen often.
    plan = '{
      '{1'b1, prtd_pkg::CLKSEL_16,   8'h00, 1'b1},
      '{1'b1, prtd_pkg::CLKSEL_64,   8'h10, 1'b0},
      '{1'b0, prtd_pkg::CLKSEL_256,  8'h55, 1'b1},
      '{1'b1, prtd_pkg::CLKSEL_16,   8'hFF, 1'b1},
      '{1'b1, prtd_pkg::CLKSEL_1024, 8'hFE, 1'b1},
      '{1'b1, prtd_pkg::CLKSEL_16,   8'hFF, 1'b1},
      '{1'b1, prtd_pkg::CLKSEL_16,   8'hFE, 1'b0},
      '{1'b1, prtd_pkg::CLKSEL_16,   8'hFF, 1'b1},
      '{1'b1, prtd_pkg::CLKSEL_1024, 8'h00, 1'b1}
    };
    plan[NumPhases-1] = '{1'($urandom_range(0, 3) != 0),
                          prtd_pkg::clk_sel_t'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), 1'b1};

    for (int p = 0; p < NumPhases; p++) begin
      wait_for_results();
      gaps_on = plan[p].gaps;
      // random upper bits check the width masking on every write
      write_reg(prtd_pkg::REG_TIMER_ENABLE, {31'($urandom), plan[p].en});
      write_reg(prtd_pkg::REG_CLOCK_SELECT, {30'($urandom), plan[p].sel});
      write_reg(prtd_pkg::REG_RELOAD_VALUE, {24'($urandom), plan[p].reload});
      if (p == 2)
        long_hold = 1'b1;
      for (int n = 0; n < PhaseTicks; n++) begin
        // one mid-phase pause of the source until the DUT is empty
        if (p == 4 && n == PhaseTicks / 2)
          wait_for_results();
        case ($urandom_range(0, 7))
          0:       step = 8'd0;
          1:       step = 8'd255;
          default: step = 8'($urandom_range(0, 255));
        endcase
        offer_tick(step, 1'b0, '0);
      end
    end

    wait_for_results();
    if (mismatches == 0) begin
      $display("PASS prescaled_reload_timer_divider");
    end else begin
      $display("FAIL prescaled_reload_timer_divider");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/prtd_pkg.sv
rtl/prescaled_reload_timer_divider.sv
bench/prescaled_reload_timer_divider_tb.sv
